@@ rtl/core/smie_pkg.sv @@
`default_nettype none

package smie_pkg;

    // Instruction opcodes in bits 15:12; codes not listed only advance the PC.
    typedef enum logic [3:0] {
        OP_LOAD_MEM = 4'h1,
        OP_LOAD_IMM = 4'h2,
        OP_STORE    = 4'h3,
        OP_MOVE     = 4'h4,
        OP_ADD_INT  = 4'h5,
        OP_ADD_FLT  = 4'h6,
        OP_JUMP     = 4'hB,
        OP_HALT     = 4'hC
    } t_op;

    localparam logic [2:0] EXP_BIAS = 3'd4;
    localparam logic [7:0] PC_STEP  = 8'd2;

    // Result item; the first member lands in the highest bits.
    typedef struct packed {
        logic       fp_overflow;
        logic       halted;
        logic [7:0] display_value;
        logic       display_valid;
        logic       branch_taken;
        logic [7:0] pc;
    } t_result;

    // Register file write request.
    typedef struct packed {
        logic       en;
        logic [3:0] addr;
        logic [7:0] data;
    } t_rwr;

    // Data memory write request.
    typedef struct packed {
        logic       en;
        logic [7:0] addr;
        logic [7:0] data;
    } t_mwr;

    // Float sum and its overflow flag.
    typedef struct packed {
        logic       ovf;
        logic [7:0] val;
    } t_fadd;

    // Add two 8-bit floats: sign, 3-bit excess-4 exponent, 4-bit mantissa.
    // Values are worked in units of 1/256; the result is truncated.
    function automatic t_fadd fl_add(input logic [7:0] a, input logic [7:0] b);
        logic [10:0]        mag_a;
        logic [10:0]        mag_b;
        logic signed [12:0] sa;
        logic signed [12:0] sb;
        logic signed [12:0] sum;
        logic [12:0]        abs_sum;
        logic [11:0]        amag;
        logic [2:0]         ex;
        logic [3:0]         mant;
        logic               neg;
        t_fadd              res;
        mag_a   = {7'd0, a[3:0]} << a[6:4];
        mag_b   = {7'd0, b[3:0]} << b[6:4];
        sa      = a[7] ? -$signed({2'b00, mag_a}) : $signed({2'b00, mag_a});
        sb      = b[7] ? -$signed({2'b00, mag_b}) : $signed({2'b00, mag_b});
        sum     = sa + sb;
        abs_sum = sum[12] ? 13'(-sum) : 13'(sum);
        amag    = abs_sum[11:0];
        res.ovf = 1'b0;
        // Pick the exponent from the length of the integer part.
        if (amag[11]) begin
            ex      = 3'd0;
            mant    = amag[11:8];
            res.ovf = 1'b1;
        end else if (amag[10]) begin
            ex   = 3'd7;
            mant = amag[10:7];
        end else if (amag[9]) begin
            ex   = 3'd6;
            mant = amag[9:6];
        end else if (amag[8]) begin
            ex   = 3'd5;
            mant = amag[8:5];
        end else begin
            ex   = EXP_BIAS;
            mant = amag[7:4];
        end
        // An exact zero is negative only when both inputs are negative zeros.
        if (sum != 13'sd0) begin
            neg = sum[12];
        end else begin
            neg = a[7] & b[7] & (a[3:0] == 4'd0) & (b[3:0] == 4'd0);
        end
        res.val = {neg, ex, mant};
        return res;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/smie_regfile.sv @@
`default_nettype none

// Sixteen 8-bit registers, two registered read ports, one write port.
// A read in the same cycle as a write to the same entry returns the new data.
module smie_regfile (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_rd_en,
    input  wire logic [3:0]        i_ra_addr,
    input  wire logic [3:0]        i_rb_addr,
    input  wire smie_pkg::t_rwr    i_wr,
    output logic      [7:0]        o_ra_data,
    output logic      [7:0]        o_rb_data
);
    import smie_pkg::*;

    logic [7:0]  r_mem [16];
    logic [15:0] r_vld;
    logic [7:0]  r_ra_data;
    logic [7:0]  r_rb_data;

    // Entry valid bits; an entry never written reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr.en) begin
            r_vld[i_wr.addr] <= 1'b1;
        end
    end

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // Registered reads with write-first bypass.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr.en && i_wr.addr == i_ra_addr) begin
                r_ra_data <= i_wr.data;
            end else begin
                r_ra_data <= r_vld[i_ra_addr] ? r_mem[i_ra_addr] : 8'd0;
            end
            if (i_wr.en && i_wr.addr == i_rb_addr) begin
                r_rb_data <= i_wr.data;
            end else begin
                r_rb_data <= r_vld[i_rb_addr] ? r_mem[i_rb_addr] : 8'd0;
            end
        end
    end

    assign o_ra_data = r_ra_data;
    assign o_rb_data = r_rb_data;

endmodule

`default_nettype wire

@@ rtl/core/smie_dmem.sv @@
`default_nettype none

// 256-byte data memory, one registered read port and one write port.
// Per-entry valid bits make unwritten bytes read as zero after reset.
module smie_dmem (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_rd_en,
    input  wire logic [7:0]        i_rd_addr,
    input  wire smie_pkg::t_mwr    i_wr,
    output logic      [7:0]        o_rd_data
);
    import smie_pkg::*;

    logic [7:0]   r_mem [256];
    logic [255:0] r_vld;
    logic [7:0]   r_rd_data;

    // Entry valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr.en) begin
            r_vld[i_wr.addr] <= 1'b1;
        end
    end

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // Registered read with write-first bypass.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr.en && i_wr.addr == i_rd_addr) begin
                r_rd_data <= i_wr.data;
            end else begin
                r_rd_data <= r_vld[i_rd_addr] ? r_mem[i_rd_addr] : 8'd0;
            end
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

@@ rtl/core/smie_exec.sv @@
`default_nettype none

// Execute logic: decodes the instruction held in the execute stage and forms
// the write-backs, the next PC and halt state, and the result item.
module smie_exec (
    input  wire logic [15:0]       i_instr,
    input  wire logic [7:0]        i_ra_data,
    input  wire logic [7:0]        i_rb_data,
    input  wire logic [7:0]        i_mem_data,
    input  wire logic [7:0]        i_pc,
    input  wire logic              i_halt,
    output smie_pkg::t_rwr         o_rwr,
    output smie_pkg::t_mwr         o_mwr,
    output logic      [7:0]        o_pc_nxt,
    output logic                   o_halt_nxt,
    output smie_pkg::t_result      o_result
);
    import smie_pkg::*;

    t_op        op;
    logic [3:0] r_fld;
    logic [3:0] y_fld;
    logic [7:0] xy;
    t_fadd      fsum;
    logic       advance;

    assign op    = t_op'(i_instr[15:12]);
    assign r_fld = i_instr[11:8];
    assign y_fld = i_instr[3:0];
    assign xy    = i_instr[7:0];
    assign fsum  = fl_add(i_ra_data, i_rb_data);

    // Decode and execute.
    always_comb begin
        o_rwr      = '0;
        o_mwr      = '0;
        o_result   = '0;
        o_halt_nxt = i_halt;
        advance    = 1'b1;
        o_pc_nxt   = i_pc;
        if (i_halt) begin
            advance = 1'b0;
        end else begin
            case (op)
                OP_LOAD_MEM: begin
                    o_rwr = '{en: 1'b1, addr: r_fld, data: i_mem_data};
                end
                OP_LOAD_IMM: begin
                    o_rwr = '{en: 1'b1, addr: r_fld, data: xy};
                end
                OP_STORE: begin
                    o_mwr = '{en: 1'b1, addr: xy, data: i_ra_data};
                    if (xy == 8'd0) begin
                        o_result.display_valid = 1'b1;
                        o_result.display_value = i_ra_data;
                    end
                end
                OP_MOVE: begin
                    o_rwr = '{en: 1'b1, addr: y_fld, data: i_ra_data};
                end
                OP_ADD_INT: begin
                    o_rwr = '{en: 1'b1, addr: r_fld, data: i_ra_data + i_rb_data};
                end
                OP_ADD_FLT: begin
                    o_rwr = '{en: 1'b1, addr: r_fld, data: fsum.val};
                    o_result.fp_overflow = fsum.ovf;
                end
                OP_JUMP: begin
                    // Port B reads register 0 for a jump.
                    if (i_ra_data == i_rb_data) begin
                        o_pc_nxt                = xy;
                        o_result.branch_taken   = 1'b1;
                        advance                 = 1'b0;
                    end
                end
                OP_HALT: begin
                    o_halt_nxt = 1'b1;
                    advance    = 1'b0;
                end
                default: begin
                end
            endcase
        end
        if (advance) begin
            o_pc_nxt = i_pc + PC_STEP;
        end
        o_result.pc     = o_pc_nxt;
        o_result.halted = o_halt_nxt;
    end

endmodule

`default_nettype wire

@@ rtl/core/simple_machine_instruction_executor_unit.sv @@
`default_nettype none

// Instruction executor for a small teaching machine: sixteen 8-bit registers,
// 256 bytes of data memory, a program counter and a sticky halt flag. Each
// input item is one 16-bit instruction; each produces exactly one result item
// carrying the new PC and status flags. The block takes one instruction per
// clock cycle while the output is not stalled: register
// file and memory reads are registered at acceptance (with write-first bypass
// from the instruction retiring in that same cycle); execution and write-back
// happen when the execute stage moves into the output register. Registers
// and memory come out of reset reading zero through per-entry valid bits,
// so there is no clearing pass and items are accepted right after reset.
module simple_machine_instruction_executor_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // [15:0] instruction
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [23:0] m_axis_tdata   // [7:0] pc, [8] branch_taken,
                                            // [9] display_valid,
                                            // [17:10] display_value,
                                            // [18] halted, [19] fp_overflow,
                                            // [23:20] zero
);
    import smie_pkg::*;

    logic        in_fire;
    logic        s1_fire;
    t_op         in_op;
    logic [3:0]  ra_addr;
    logic [3:0]  rb_addr;

    logic        r_s1_valid;
    logic [15:0] r_s1_instr;
    logic [7:0]  r_pc;
    logic        r_halt;
    logic        r_out_valid;
    t_result     r_out;

    logic [7:0]  ra_data;
    logic [7:0]  rb_data;
    logic [7:0]  mem_data;
    t_rwr        rwr;
    t_mwr        mwr;
    t_rwr        rwr_g;
    t_mwr        mwr_g;
    logic [7:0]  n_pc;
    logic        n_halt;
    t_result     n_out;

    // Handshake: the execute stage moves when the output register is free.
    assign s1_fire       = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || s1_fire;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // Register read addresses from the incoming instruction.
    assign in_op = t_op'(s_axis_tdata[15:12]);
    always_comb begin
        ra_addr = s_axis_tdata[11:8];
        rb_addr = s_axis_tdata[3:0];
        case (in_op)
            OP_MOVE, OP_ADD_INT, OP_ADD_FLT: begin
                ra_addr = s_axis_tdata[7:4];
            end
            OP_JUMP: begin
                rb_addr = 4'd0;
            end
            default: begin
            end
        endcase
    end

    // Writes only happen when the instruction retires.
    always_comb begin
        rwr_g    = rwr;
        mwr_g    = mwr;
        rwr_g.en = rwr.en && s1_fire;
        mwr_g.en = mwr.en && s1_fire;
    end

    smie_regfile u_regfile (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_fire),
        .i_ra_addr (ra_addr),
        .i_rb_addr (rb_addr),
        .i_wr      (rwr_g),
        .o_ra_data (ra_data),
        .o_rb_data (rb_data)
    );

    smie_dmem u_dmem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_fire),
        .i_rd_addr (s_axis_tdata[7:0]),
        .i_wr      (mwr_g),
        .o_rd_data (mem_data)
    );

    smie_exec u_exec (
        .i_instr    (r_s1_instr),
        .i_ra_data  (ra_data),
        .i_rb_data  (rb_data),
        .i_mem_data (mem_data),
        .i_pc       (r_pc),
        .i_halt     (r_halt),
        .o_rwr      (rwr),
        .o_mwr      (mwr),
        .o_pc_nxt   (n_pc),
        .o_halt_nxt (n_halt),
        .o_result   (n_out)
    );

    // Execute stage and machine state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_pc       <= '0;
            r_halt     <= 1'b0;
        end else begin
            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_pc   <= n_pc;
                r_halt <= n_halt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_instr <= s_axis_tdata;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_out};

    // The halt flag never clears once set.
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt)
        else $error("halt flag cleared");

    // A halted machine neither writes registers nor memory.
    a_halt_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |-> (!rwr.en && !mwr.en))
        else $error("write while halted");

    // Overflow only comes from a float add, never from a halted machine.
    a_ovf_not_halted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.fp_overflow) |-> !r_out.halted)
        else $error("overflow reported with halt");

    // A retiring instruction loads its PC and halt state into the machine.
    a_pc_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire |=> (r_pc == r_out.pc && r_halt == r_out.halted))
        else $error("machine state differs from result");

    // An empty execute stage always takes a new instruction.
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_valid |-> s_axis_tready)
        else $error("stall with empty execute stage");

endmodule

`default_nettype wire
